// ----- rtl/rbi_pkg.sv -----
package rbi_pkg;

    localparam int FRAC_BITS = 16;
    localparam int W = 32;
    localparam int DVD_W = W + FRAC_BITS;
    localparam int DIV_STEPS = DVD_W;
    localparam int LAT_GF = 3;
    localparam int LAT_DIV = DIV_STEPS + 2;
    localparam int LAT_INT = 6;
    localparam int LAT_TOTAL = LAT_GF + LAT_DIV + LAT_INT + 1;

    localparam logic [1:0] REG_GRAVITY_X = 2'd0;
    localparam logic [1:0] REG_GRAVITY_Y = 2'd1;
    localparam logic [1:0] REG_TIME_STEP = 2'd2;

    localparam logic signed [W-1:0] GRAVITY_X_RST = 32'sd0;
    localparam logic signed [W-1:0] GRAVITY_Y_RST = -32'sd642908;
    localparam logic [15:0] TIME_STEP_RST = 16'd1092;

    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

    function automatic logic signed [W-1:0] sat32(input logic signed [63:0] v);
        if (v > S32_MAX) return S32_MAX[W-1:0];
        if (v < S32_MIN) return S32_MIN[W-1:0];
        return v[W-1:0];
    endfunction

    function automatic logic ovf32(input logic signed [63:0] v);
        return (v > S32_MAX) || (v < S32_MIN);
    endfunction

endpackage

// ----- rtl/rbi_gforce.sv -----
module rbi_gforce
    import rbi_pkg::*;
(
    input  logic                i_clk,
    input  logic signed [W-1:0] i_gs,
    input  logic signed [W-1:0] i_grav,
    input  logic [30:0]         i_mass,
    input  logic signed [W-1:0] i_force,
    output logic signed [W-1:0] o_force,
    output logic                o_flag
);
    logic signed [63:0] r_prod;
    logic signed [63:0] r_gm;
    logic [30:0]        r_mass;
    logic signed [W-1:0] r_f1, r_f2, r_fo;
    logic               r_fl2, r_flo;
    logic signed [W-1:0] n_g, n_t;
    logic signed [W:0]  n_sum;

    always_comb begin
        n_g = sat32(r_prod >>> FRAC_BITS);
        n_t = sat32(r_gm >>> FRAC_BITS);
        n_sum = {n_t[W-1], n_t} + {r_f2[W-1], r_f2};
    end

    always_ff @(posedge i_clk) begin
        // gravity scale times gravity
        r_prod <= i_gs * i_grav;
        r_mass <= i_mass;
        r_f1   <= i_force;
        // times mass
        r_gm   <= n_g * $signed({1'b0, r_mass});
        r_fl2  <= ovf32(r_prod >>> FRAC_BITS);
        r_f2   <= r_f1;
        // add to external force
        r_fo   <= sat32(n_sum);
        r_flo  <= r_fl2 | ovf32(r_gm >>> FRAC_BITS) | ovf32(n_sum);
    end

    assign o_force = r_fo;
    assign o_flag  = r_flo;
endmodule

// ----- rtl/rbi_div.sv -----
module rbi_div
    import rbi_pkg::*;
(
    input  logic                i_clk,
    input  logic signed [W-1:0] i_force,
    input  logic [30:0]         i_mass,
    output logic signed [W-1:0] o_accel,
    output logic                o_flag
);
    logic [W-1:0]     r_rem [0:DIV_STEPS];
    logic [DVD_W-1:0] r_dvd [0:DIV_STEPS];
    logic [DVD_W-1:0] r_q   [0:DIV_STEPS];
    logic [30:0]      r_m   [0:DIV_STEPS];
    logic             r_neg [0:DIV_STEPS];
    logic             r_zero[0:DIV_STEPS];
    logic signed [W-1:0] r_acc;
    logic             r_fl;
    logic [W-1:0]     n_mag;
    logic [DVD_W-1:0] n_q;
    logic             n_big, n_min;

    assign n_mag = i_force[W-1] ? W'(-i_force) : W'(i_force);

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= '0;
        r_dvd[0]  <= {n_mag, {FRAC_BITS{1'b0}}};
        r_q[0]    <= '0;
        r_m[0]    <= i_mass;
        r_neg[0]  <= i_force[W-1];
        r_zero[0] <= (i_mass == '0);
    end

    // one quotient bit per stage, restoring
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [W-1:0] n_try;
        logic         n_ge;
        assign n_try = {r_rem[k][W-2:0], r_dvd[k][DVD_W-1]};
        assign n_ge  = n_try >= {1'b0, r_m[k]};
        always_ff @(posedge i_clk) begin
            r_rem[k+1]  <= n_ge ? n_try - {1'b0, r_m[k]} : n_try;
            r_dvd[k+1]  <= {r_dvd[k][DVD_W-2:0], 1'b0};
            r_q[k+1]    <= {r_q[k][DVD_W-2:0], n_ge};
            r_m[k+1]    <= r_m[k];
            r_neg[k+1]  <= r_neg[k];
            r_zero[k+1] <= r_zero[k];
        end
    end

    assign n_q   = r_q[DIV_STEPS];
    assign n_big = n_q[DVD_W-1:W-1] != '0;
    assign n_min = n_q == (DVD_W'(1) << (W - 1));

    always_ff @(posedge i_clk) begin
        if (r_zero[DIV_STEPS]) begin
            r_acc <= r_neg[DIV_STEPS] ? S32_MIN[W-1:0] : S32_MAX[W-1:0];
            r_fl  <= 1'b1;
        end else if (r_neg[DIV_STEPS]) begin
            r_acc <= (n_big && !n_min) ? S32_MIN[W-1:0] : W'(-n_q);
            r_fl  <= n_big && !n_min;
        end else begin
            r_acc <= n_big ? S32_MAX[W-1:0] : n_q[W-1:0];
            r_fl  <= n_big;
        end
    end

    assign o_accel = r_acc;
    assign o_flag  = r_fl;
endmodule

// ----- rtl/rbi_integ.sv -----
module rbi_integ
    import rbi_pkg::*;
(
    input  logic                i_clk,
    input  logic signed [W-1:0] i_acc,
    input  logic signed [W-1:0] i_pos,
    input  logic signed [W-1:0] i_vel,
    input  logic [15:0]         i_dt,
    input  logic [30:0]         i_damp,
    output logic signed [W-1:0] o_pos,
    output logic signed [W-1:0] o_vel,
    output logic                o_flag
);
    localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

    logic signed [47:0] r_pa;
    logic signed [W-1:0] r_pos1, r_vel1, r_pos2, r_pos3, r_pos4;
    logic [15:0]  r_dt1, r_dt2;
    logic [30:0]  r_dm1, r_dm2;
    logic signed [W-1:0] r_kick2, r_v12, r_kick3, r_v13;
    logic         r_fl2, r_fl3, r_fl4, r_fl5, r_fl6;
    logic signed [47:0] r_pv;
    logic [46:0]  r_pd;
    logic signed [W-1:0] r_v24, r_p5, r_p6, r_nv;
    logic [FRAC_BITS:0] r_fac;
    logic signed [48:0] r_pf;
    logic signed [W-1:0] n_kick, n_dp, n_v2;
    logic signed [W:0]   n_s1, n_s2, n_s3;
    logic [30:0]  n_dd;

    always_comb begin
        n_kick = sat32(r_pa >>> (FRAC_BITS + 1));
        n_s1 = {r_vel1[W-1], r_vel1} + {n_kick[W-1], n_kick};
        n_dp = sat32(r_pv >>> FRAC_BITS);
        n_s2 = {r_pos3[W-1], r_pos3} + {n_dp[W-1], n_dp};
        n_s3 = {r_v13[W-1], r_v13} + {r_kick3[W-1], r_kick3};
        n_v2 = sat32(n_s3);
        n_dd = 31'(r_pd >> FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        // acceleration times dt
        r_pa   <= i_acc * $signed({1'b0, i_dt});
        r_pos1 <= i_pos;
        r_vel1 <= i_vel;
        r_dt1  <= i_dt;
        r_dm1  <= i_damp;
        // first half kick
        r_kick2 <= n_kick;
        r_v12   <= sat32(n_s1);
        r_fl2   <= ovf32(r_pa >>> (FRAC_BITS + 1)) | ovf32(n_s1);
        r_pos2  <= r_pos1;
        r_dt2   <= r_dt1;
        r_dm2   <= r_dm1;
        // drift and damping products
        r_pv    <= r_v12 * $signed({1'b0, r_dt2});
        r_pd    <= r_dt2 * r_dm2;
        r_kick3 <= r_kick2;
        r_v13   <= r_v12;
        r_pos3  <= r_pos2;
        r_fl3   <= r_fl2;
        // position, second half kick, damping factor
        r_pos4  <= sat32(n_s2);
        r_v24   <= n_v2;
        r_fac   <= (n_dd > 31'(ONE)) ? '0 : ONE - (FRAC_BITS+1)'(n_dd);
        r_fl4   <= r_fl3 | ovf32(r_pv >>> FRAC_BITS) | ovf32(n_s2) | ovf32(n_s3);
        // damped velocity
        r_pf    <= r_v24 * $signed({1'b0, r_fac});
        r_p5    <= r_pos4;
        r_fl5   <= r_fl4;
        r_nv    <= W'(r_pf >>> FRAC_BITS);
        r_p6    <= r_p5;
        r_fl6   <= r_fl5;
    end

    assign o_pos  = r_p6;
    assign o_vel  = r_nv;
    assign o_flag = r_fl6;
endmodule

// ----- rtl/rigid_body_integrate_2d_unit.sv -----
// channel | direction | handshake               | word
// body    | in        | i_start & !o_busy        | dynamic flag, pos, vel, force, mass, ...
// result  | out       | o_strobe, one cycle      | new pos, new vel, accel, saturated
// config  | in        | i_cfg_we                 | i_cfg_idx, i_cfg_data
//
// one body enters every cycle while o_busy is low; its result then passes through
// the gravity-force stages, the 48-step quotient pipeline for force over mass, the integrator and the output register
// o_busy is high only while i_rst_n is low; reset clears the valid bits
// and loads the register defaults
// the receiver cannot stall, so the pipeline advances every cycle
module rigid_body_integrate_2d_unit
    import rbi_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic                i_body_is_dynamic,
    input  logic signed [W-1:0] i_pos_x,
    input  logic signed [W-1:0] i_pos_y,
    input  logic signed [W-1:0] i_vel_x,
    input  logic signed [W-1:0] i_vel_y,
    input  logic signed [W-1:0] i_force_x,
    input  logic signed [W-1:0] i_force_y,
    input  logic [30:0]         i_mass,
    input  logic signed [W-1:0] i_gravity_scale,
    input  logic [30:0]         i_damping_x,
    input  logic [30:0]         i_damping_y,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data,
    output logic                o_strobe,
    output logic signed [W-1:0] o_new_pos_x,
    output logic signed [W-1:0] o_new_pos_y,
    output logic signed [W-1:0] o_new_vel_x,
    output logic signed [W-1:0] o_new_vel_y,
    output logic signed [W-1:0] o_accel_x,
    output logic signed [W-1:0] o_accel_y,
    output logic                o_saturated
);
    localparam int LAT_A = LAT_GF + LAT_DIV;

    typedef struct packed {
        logic                dyn;
        logic signed [W-1:0] px, py, vx, vy;
        logic [30:0]         dx, dy;
    } t_side;

    typedef struct packed {
        logic                dyn;
        logic signed [W-1:0] px, py, vx, vy, ax, ay;
    } t_tail;

    // config registers
    logic signed [W-1:0] r_grav_x, r_grav_y;
    logic [15:0]         r_dt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav_x <= GRAVITY_X_RST;
            r_grav_y <= GRAVITY_Y_RST;
            r_dt     <= TIME_STEP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_GRAVITY_X: r_grav_x <= i_cfg_data;
                REG_GRAVITY_Y: r_grav_y <= i_cfg_data;
                REG_TIME_STEP: r_dt     <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic n_acc;
    assign o_busy = !i_rst_n;
    assign n_acc  = i_start && !o_busy;

    // valid bits for the whole depth
    logic [LAT_TOTAL-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else          r_vld <= {r_vld[LAT_TOTAL-2:0], n_acc};
    end

    // body sideband alongside the force and divide stages
    t_side r_sa [0:LAT_A-1];
    always_ff @(posedge i_clk) begin
        r_sa[0] <= '{i_body_is_dynamic, i_pos_x, i_pos_y, i_vel_x, i_vel_y,
                     i_damping_x, i_damping_y};
        for (int k = 1; k < LAT_A; k++) r_sa[k] <= r_sa[k-1];
    end

    // gravity force
    logic signed [W-1:0] w_fx, w_fy;
    logic                w_gfx, w_gfy;
    rbi_gforce u_gf_x (.i_clk, .i_gs(i_gravity_scale), .i_grav(r_grav_x),
                       .i_mass, .i_force(i_force_x), .o_force(w_fx), .o_flag(w_gfx));
    rbi_gforce u_gf_y (.i_clk, .i_gs(i_gravity_scale), .i_grav(r_grav_y),
                       .i_mass, .i_force(i_force_y), .o_force(w_fy), .o_flag(w_gfy));

    // mass delayed to meet the force
    logic [30:0] r_md [0:LAT_GF-1];
    always_ff @(posedge i_clk) begin
        r_md[0] <= i_mass;
        for (int k = 1; k < LAT_GF; k++) r_md[k] <= r_md[k-1];
    end

    // acceleration
    logic signed [W-1:0] w_ax, w_ay;
    logic                w_dfx, w_dfy;
    rbi_div u_div_x (.i_clk, .i_force(w_fx), .i_mass(r_md[LAT_GF-1]),
                     .o_accel(w_ax), .o_flag(w_dfx));
    rbi_div u_div_y (.i_clk, .i_force(w_fy), .i_mass(r_md[LAT_GF-1]),
                     .o_accel(w_ay), .o_flag(w_dfy));

    // gravity-force flag waits out the divider
    logic r_gfl [0:LAT_DIV-1];
    always_ff @(posedge i_clk) begin
        r_gfl[0] <= w_gfx | w_gfy;
        for (int k = 1; k < LAT_DIV; k++) r_gfl[k] <= r_gfl[k-1];
    end

    // kick, drift, kick and damping
    t_side  w_s;
    assign w_s = r_sa[LAT_A-1];
    logic signed [W-1:0] w_npx, w_npy, w_nvx, w_nvy;
    logic                w_ifx, w_ify;
    rbi_integ u_int_x (.i_clk, .i_acc(w_ax), .i_pos(w_s.px), .i_vel(w_s.vx),
                       .i_dt(r_dt), .i_damp(w_s.dx),
                       .o_pos(w_npx), .o_vel(w_nvx), .o_flag(w_ifx));
    rbi_integ u_int_y (.i_clk, .i_acc(w_ay), .i_pos(w_s.py), .i_vel(w_s.vy),
                       .i_dt(r_dt), .i_damp(w_s.dy),
                       .o_pos(w_npy), .o_vel(w_nvy), .o_flag(w_ify));

    // pass-through values and earlier flags alongside the integrator
    t_tail r_tl [0:LAT_INT-1];
    logic  r_tfl[0:LAT_INT-1];
    always_ff @(posedge i_clk) begin
        r_tl[0]  <= '{w_s.dyn, w_s.px, w_s.py, w_s.vx, w_s.vy, w_ax, w_ay};
        r_tfl[0] <= r_gfl[LAT_DIV-1] | w_dfx | w_dfy;
        for (int k = 1; k < LAT_INT; k++) begin
            r_tl[k]  <= r_tl[k-1];
            r_tfl[k] <= r_tfl[k-1];
        end
    end

    // output register; static bodies pass through untouched
    t_tail w_t;
    assign w_t = r_tl[LAT_INT-1];
    logic signed [W-1:0] r_opx, r_opy, r_ovx, r_ovy, r_oax, r_oay;
    logic                r_osat;
    always_ff @(posedge i_clk) begin
        if (w_t.dyn) begin
            r_opx  <= w_npx;
            r_opy  <= w_npy;
            r_ovx  <= w_nvx;
            r_ovy  <= w_nvy;
            r_oax  <= w_t.ax;
            r_oay  <= w_t.ay;
            r_osat <= r_tfl[LAT_INT-1] | w_ifx | w_ify;
        end else begin
            r_opx  <= w_t.px;
            r_opy  <= w_t.py;
            r_ovx  <= w_t.vx;
            r_ovy  <= w_t.vy;
            r_oax  <= '0;
            r_oay  <= '0;
            r_osat <= 1'b0;
        end
    end

    assign o_strobe    = r_vld[LAT_TOTAL-1];
    assign o_new_pos_x = r_opx;
    assign o_new_pos_y = r_opy;
    assign o_new_vel_x = r_ovx;
    assign o_new_vel_y = r_ovy;
    assign o_accel_x   = r_oax;
    assign o_accel_y   = r_oay;
    assign o_saturated = r_osat;
endmodule

// ----- rtl/rbi_checker.sv -----
module rbi_sva
    import rbi_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_start,
    input logic                o_busy,
    input logic                i_body_is_dynamic,
    input logic signed [W-1:0] i_pos_x,
    input logic signed [W-1:0] i_vel_y,
    input logic                o_strobe,
    input logic signed [W-1:0] o_new_pos_x,
    input logic signed [W-1:0] o_new_vel_y,
    input logic signed [W-1:0] o_accel_x,
    input logic signed [W-1:0] o_accel_y,
    input logic                o_saturated
);
    logic w_acc, w_stat;
    assign w_acc  = i_start && !o_busy;
    assign w_stat = w_acc && !i_body_is_dynamic;

    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(w_acc, LAT_TOTAL) |-> o_strobe) else $error("result strobe missing");

    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(w_acc, LAT_TOTAL)) else $error("result strobe off latency");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_strobe)
        else $error("strobe right after reset");

    a_stat_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && $past(w_stat, LAT_TOTAL) |->
        o_accel_x == 0 && o_accel_y == 0 && !o_saturated)
        else $error("static body with accel or flag");

    a_stat_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && $past(w_stat, LAT_TOTAL) |->
        o_new_pos_x == $past(i_pos_x, LAT_TOTAL) && o_new_vel_y == $past(i_vel_y, LAT_TOTAL))
        else $error("static body changed");
endmodule

bind rigid_body_integrate_2d_unit rbi_sva u_rbi_sva (
    .i_clk, .i_rst_n, .i_start, .o_busy, .i_body_is_dynamic, .i_pos_x, .i_vel_y,
    .o_strobe, .o_new_pos_x, .o_new_vel_y, .o_accel_x, .o_accel_y, .o_saturated
);
